>>> rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants of the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

    // Expression characters
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_MUL   = 8'h2A;
    localparam logic [7:0] SYM_DIV   = 8'h2F;
    localparam logic [7:0] SYM_ZERO  = 8'h30;

    // Value returned by a pop of an empty stack
    localparam logic [31:0] POP_EMPTY = 32'hFFFF_FFFF;

    // Error status codes, first one wins
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    // Decoded character
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_Y,
        S_POP_X,
        S_CAP_X,
        S_EXEC,
        S_DIV,
        S_PUSH,
        S_POP_F,
        S_FINISH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic push;
        logic pop;
        logic cap_y;
        logic cap_x;
        logic exec;
        logic div_start;
        logic res_div;
        logic out_load;
        logic clear;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_oper;
        logic is_div;
        logic is_last;
        logic y_zero;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

>>> rtl/pse_div.sv
// ----------------------------------------------------------------------------
// pse_div
// Signed 32-bit divider, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pse_div
    import pse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic        r_neg;
    logic [31:0] r_num;
    logic [31:0] r_den;
    logic [31:0] r_rem;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    // Restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        rem_sh = {r_rem, r_num[31]};
        diff   = rem_sh - {1'b0, r_den};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Magnitudes in, quotient bits shift into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_x[31] ? (32'd0 - i_x) : i_x;
            r_den <= i_y[31] ? (32'd0 - i_y) : i_y;
            r_rem <= '0;
            r_neg <= i_x[31] ^ i_y[31];
        end else if (r_busy) begin
            r_num <= {r_num[30:0], ~diff[32]};
            r_rem <= diff[32] ? rem_sh[31:0] : diff[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (32'd0 - r_num) : r_num;

endmodule

>>> rtl/pse_dpath.sv
// ----------------------------------------------------------------------------
// pse_dpath
// Operand stack, ALU, divider, error tracking and result register.
// ----------------------------------------------------------------------------
module pse_dpath
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [7:0]  i_symbol,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [31:0]   mem [STACK_DEPTH];
    logic [31:0]   r_rdata;
    logic          r_pop_empty;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_status       r_err;
    t_status       n_err;
    logic [7:0]    r_sym;
    logic          r_last;
    logic [31:0]   r_y;
    logic [31:0]   r_x;
    logic [31:0]   r_res;
    logic          r_out_valid;
    logic [31:0]   r_out_value;
    t_status       r_out_status;
    t_op           op;
    logic          full;
    logic          empty;
    logic [31:0]   pop_val;
    logic [31:0]   push_val;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] wr_idx;
    logic [AW-1:0] rd_idx;
    logic [CW-1:0] cnt_m1;
    logic          div_done;
    logic [31:0]   div_quot;

    // Character decode
    always_comb begin
        unique case (r_sym)
            SYM_PLUS:  op = OP_ADD;
            SYM_MINUS: op = OP_SUB;
            SYM_MUL:   op = OP_MUL;
            SYM_DIV:   op = OP_DIV;
            default:   op = OP_NONE;
        endcase
    end

    // Stack pointers and data
    always_comb begin
        full     = (r_count == CW'(STACK_DEPTH));
        empty    = (r_count == '0);
        cnt_m1   = r_count - CW'(1);
        wr_idx   = r_count[AW-1:0];
        rd_idx   = cnt_m1[AW-1:0];
        pop_val  = r_pop_empty ? POP_EMPTY : r_rdata;
        push_val = (op == OP_NONE) ? ({24'd0, r_sym} - {24'd0, SYM_ZERO}) : r_res;
        wr_en    = i_cmd.push && !full;
        rd_en    = i_cmd.pop && !empty;
    end

    // Stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= push_val;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_idx];
        end
    end

    // Count and first-error tracking
    always_comb begin
        n_count = r_count;
        n_err   = r_err;
        if (i_cmd.clear) begin
            n_count = '0;
            n_err   = ST_OK;
        end else if (i_cmd.push) begin
            if (full) begin
                if (r_err == ST_OK) n_err = ST_OVER;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (i_cmd.pop) begin
            if (empty) begin
                if (r_err == ST_OK) n_err = ST_UNDER;
            end else begin
                n_count = cnt_m1;
            end
        end else if (i_cmd.exec && op == OP_DIV && r_y == '0) begin
            if (r_err == ST_OK) n_err = ST_DIVZ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_pop_empty <= 1'b0;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
            if (i_cmd.pop) r_pop_empty <= empty;
        end
    end

    // Input beat and operand capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sym  <= i_symbol;
            r_last <= i_last;
        end
        if (i_cmd.cap_y) r_y <= pop_val;
        if (i_cmd.cap_x) r_x <= pop_val;
    end

    // ALU result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            case (op)
                OP_ADD:  r_res <= r_x + r_y;
                OP_SUB:  r_res <= r_x - r_y;
                OP_MUL:  r_res <= r_x * r_y;
                default: r_res <= '0;
            endcase
        end else if (i_cmd.res_div) begin
            r_res <= div_quot;
        end
    end

    pse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_x     (r_x),
        .i_y     (r_y),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= pop_val;
            r_out_status <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;

    // Status to controller
    always_comb begin
        o_sts.is_oper  = (op != OP_NONE);
        o_sts.is_div   = (op == OP_DIV);
        o_sts.is_last  = r_last;
        o_sts.y_zero   = (r_y == '0);
        o_sts.div_done = div_done;
        o_sts.out_busy = r_out_valid && !i_out_ready;
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_count == '0) && (r_err == ST_OK))
        else $error("clear did not empty the stack");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid || i_out_ready)
        else $error("result register overwritten");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push && full |=> (r_count == CW'(STACK_DEPTH)) && (r_err != ST_OK))
        else $error("overflow push mishandled");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> r_y != '0)
        else $error("divider started with zero divisor");

endmodule

>>> rtl/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Sequencer: pops, operates, pushes and emits for one character at a time.
// ----------------------------------------------------------------------------
module pse_ctrl
    import pse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECODE;
            S_DECODE: n_state = i_sts.is_oper ? S_POP_Y : S_PUSH;
            S_POP_Y:  n_state = S_POP_X;
            S_POP_X:  n_state = S_CAP_X;
            S_CAP_X:  n_state = S_EXEC;
            S_EXEC:   n_state = (i_sts.is_div && !i_sts.y_zero) ? S_DIV : S_PUSH;
            S_DIV:    if (i_sts.div_done) n_state = S_PUSH;
            S_PUSH:   n_state = i_sts.is_last ? S_POP_F : S_IDLE;
            S_POP_F:  if (!i_sts.out_busy) n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_POP_Y: o_cmd.pop = 1'b1;
            S_POP_X: begin
                o_cmd.cap_y = 1'b1;
                o_cmd.pop   = 1'b1;
            end
            S_CAP_X: o_cmd.cap_x = 1'b1;
            S_EXEC: begin
                o_cmd.exec      = 1'b1;
                o_cmd.div_start = i_sts.is_div && !i_sts.y_zero;
            end
            S_DIV:    o_cmd.res_div = i_sts.div_done;
            S_PUSH:   o_cmd.push    = 1'b1;
            S_POP_F:  o_cmd.pop     = !i_sts.out_busy;
            S_FINISH: begin
                o_cmd.out_load = 1'b1;
                o_cmd.clear    = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Postfix expression evaluator over a bounded stack of 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one expression character
//   per beat plus a last flag. Operators + - * / pop two values and push the
//   result; any other byte pushes its value minus 48.
//   Output channel (o_out_valid / i_out_ready) carries one beat per
//   expression: the final popped value and the first error seen
//   (0 ok, 1 underflow, 2 overflow, 3 divide by zero).
//   Per character: an operand is decoded and pushed; + - * are decoded,
//   pop two values, execute and push; / waits on the bit-serial divider
//   unless the divisor is zero. A last character adds a final pop and
//   result load. One character is in work at a time; o_in_ready is high
//   only between characters.
//   Result is held in an output register: the next expression is accepted
//   while it waits. A stalled receiver only holds the block when another
//   result is ready to be loaded.
//   Reset empties the stack, clears the error and drops o_out_valid; no
//   memory clearing pass is needed.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_symbol,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);

    t_cmd cmd;
    t_sts sts;

    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pse_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_symbol    (i_symbol),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_status    (o_status)
    );

endmodule
